// File: hdl/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared widths, types and constants for the quaternion to rotation matrix
// pipeline.
// ----------------------------------------------------------------------------
package qrm_pkg;

    localparam int N_LANES = 9;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 16;
    localparam int PROD_W  = 32;
    localparam int NUM_W   = 35;
    localparam int REM_W   = 34;
    localparam int QUO_W   = 16;
    localparam int ONE_Q14 = 16384;

    typedef logic signed [IN_W-1:0]   t_in;
    typedef logic signed [OUT_W-1:0]  t_out;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic [REM_W-1:0]         t_rem;
    typedef logic [QUO_W-1:0]         t_quo;

    // control that travels with each request through the divider stages
    typedef struct packed {
        logic               valid;
        logic               degen;
        logic [N_LANES-1:0] neg;
        t_rem               div;
    } t_div_ctl;

endpackage

// File: hdl/qrm_front.sv
// ----------------------------------------------------------------------------
// qrm_front
// Products of the quaternion components, then matrix numerators, squared
// norm, signs and magnitudes. Two register stages.
// ----------------------------------------------------------------------------
module qrm_front
    import qrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in      i_w,
    input  t_in      i_x,
    input  t_in      i_y,
    input  t_in      i_z,
    output t_div_ctl o_ctl,
    output t_rem     o_mag [N_LANES]
);

    logic  r_p_valid;
    t_prod r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    t_div_ctl r_ctl;
    t_rem     r_mag [N_LANES];

    t_num     s_ww, s_xx, s_yy, s_zz, s_xy, s_xz, s_yz, s_wx, s_wy, s_wz;
    t_num     n_num [N_LANES];
    t_num     n_n2;
    t_num     n_abs [N_LANES];
    t_div_ctl n_ctl;
    t_rem     n_mag [N_LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ww <= i_w * i_w;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_xz <= i_x * i_z;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
            r_wy <= i_w * i_y;
            r_wz <= i_w * i_z;
        end
    end

    always_comb begin
        s_ww = NUM_W'(r_ww);
        s_xx = NUM_W'(r_xx);
        s_yy = NUM_W'(r_yy);
        s_zz = NUM_W'(r_zz);
        s_xy = NUM_W'(r_xy);
        s_xz = NUM_W'(r_xz);
        s_yz = NUM_W'(r_yz);
        s_wx = NUM_W'(r_wx);
        s_wy = NUM_W'(r_wy);
        s_wz = NUM_W'(r_wz);
        n_n2     = s_ww + s_xx + s_yy + s_zz;
        n_num[0] = s_ww + s_xx - s_yy - s_zz;
        n_num[1] = (s_xy - s_wz) <<< 1;
        n_num[2] = (s_xz + s_wy) <<< 1;
        n_num[3] = (s_xy + s_wz) <<< 1;
        n_num[4] = s_ww - s_xx + s_yy - s_zz;
        n_num[5] = (s_yz - s_wx) <<< 1;
        n_num[6] = (s_xz - s_wy) <<< 1;
        n_num[7] = (s_yz + s_wx) <<< 1;
        n_num[8] = s_ww - s_xx - s_yy + s_zz;
        n_ctl.valid = r_p_valid;
        n_ctl.degen = (n_n2 == '0);
        // divisor is twice the squared norm
        n_ctl.div   = {n_n2[REM_W-2:0], 1'b0};
        for (int i = 0; i < N_LANES; i++) begin
            n_ctl.neg[i] = n_num[i][NUM_W-1];
            n_abs[i]     = n_num[i][NUM_W-1] ? -n_num[i] : n_num[i];
            n_mag[i]     = n_abs[i][REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= n_ctl.valid;
        end
        if (i_en) begin
            r_ctl.degen <= n_ctl.degen;
            r_ctl.neg   <= n_ctl.neg;
            r_ctl.div   <= n_ctl.div;
            r_mag       <= n_mag;
        end
    end

    assign o_ctl = r_ctl;
    assign o_mag = r_mag;

endmodule

// File: hdl/qrm_div_stage.sv
// ----------------------------------------------------------------------------
// qrm_div_stage
// One restoring division step for all nine lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module qrm_div_stage
    import qrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_div_ctl i_ctl,
    input  t_rem     i_rem [N_LANES],
    input  t_quo     i_quo [N_LANES],
    output t_div_ctl o_ctl,
    output t_rem     o_rem [N_LANES],
    output t_quo     o_quo [N_LANES]
);

    t_div_ctl r_ctl;
    t_rem     r_rem [N_LANES];
    t_quo     r_quo [N_LANES];

    logic [REM_W:0] n_dbl [N_LANES];
    logic [REM_W:0] n_sub [N_LANES];
    logic           n_ge  [N_LANES];
    t_rem           n_rem [N_LANES];
    t_quo           n_quo [N_LANES];

    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            n_dbl[i] = {i_rem[i], 1'b0};
            n_sub[i] = n_dbl[i] - {1'b0, i_ctl.div};
            n_ge[i]  = (n_dbl[i] >= {1'b0, i_ctl.div});
            n_rem[i] = n_ge[i] ? n_sub[i][REM_W-1:0] : n_dbl[i][REM_W-1:0];
            n_quo[i] = {i_quo[i][QUO_W-2:0], n_ge[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.degen <= i_ctl.degen;
            r_ctl.neg   <= i_ctl.neg;
            r_ctl.div   <= i_ctl.div;
            r_rem       <= n_rem;
            r_quo       <= n_quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

// File: hdl/qrm_back.sv
// ----------------------------------------------------------------------------
// qrm_back
// Rounding, sign, clamp and identity substitution into the output register.
// ----------------------------------------------------------------------------
module qrm_back
    import qrm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_div_ctl i_ctl,
    input  t_quo     i_quo [N_LANES],
    output logic     o_valid,
    output logic     o_degen,
    output t_out     o_rot [N_LANES]
);

    logic r_valid;
    logic r_degen;
    t_out r_rot [N_LANES];

    logic [QUO_W:0]   n_inc [N_LANES];
    logic [QUO_W-1:0] n_rnd [N_LANES];
    logic [QUO_W-1:0] n_sat [N_LANES];
    t_out             n_rot [N_LANES];

    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            // quotient is floor(2*ratio); halves round away from zero
            n_inc[i] = {1'b0, i_quo[i]} + (QUO_W+1)'(1);
            n_rnd[i] = n_inc[i][QUO_W:1];
            n_sat[i] = (n_rnd[i] > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : n_rnd[i];
            if (i_ctl.degen) begin
                n_rot[i] = (i % 4 == 0) ? OUT_W'(ONE_Q14) : '0;
            end else begin
                n_rot[i] = i_ctl.neg[i] ? -$signed(OUT_W'(n_sat[i]))
                                        : $signed(OUT_W'(n_sat[i]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_degen <= i_ctl.degen;
            r_rot   <= n_rot;
        end
    end

    assign o_valid = r_valid;
    assign o_degen = r_degen;
    assign o_rot   = r_rot;

endmodule

// File: hdl/quaternion_to_rotation_matrix_core.sv
// A request passes through the front register stages, the divider stages and the output register.
// Throughput: one request per cycle without stalls; a 16-step pipelined
// restoring divider (one quotient bit per stage, nine lanes) sets the depth.
// The whole pipeline advances while the output register is empty or taken.
// Reset (synchronous, active low) clears only the valid bits.
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// Normalizes a Q1.15 quaternion and emits its Q2.14 rotation matrix.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core
    import qrm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [15:0] o_rot_r0c0,
    output logic signed [15:0] o_rot_r0c1,
    output logic signed [15:0] o_rot_r0c2,
    output logic signed [15:0] o_rot_r1c0,
    output logic signed [15:0] o_rot_r1c1,
    output logic signed [15:0] o_rot_r1c2,
    output logic signed [15:0] o_rot_r2c0,
    output logic signed [15:0] o_rot_r2c1,
    output logic signed [15:0] o_rot_r2c2,
    output logic              o_was_degenerate
);

    logic     en;
    t_div_ctl ctl [QUO_W+1];
    t_rem     rem [QUO_W+1][N_LANES];
    t_quo     quo [QUO_W+1][N_LANES];
    t_out     rot [N_LANES];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    qrm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_ctl   (ctl[0]),
        .o_mag   (rem[0])
    );

    always_comb begin
        for (int i = 0; i < N_LANES; i++) begin
            quo[0][i] = '0;
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_div
        qrm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[s]),
            .i_rem   (rem[s]),
            .i_quo   (quo[s]),
            .o_ctl   (ctl[s+1]),
            .o_rem   (rem[s+1]),
            .o_quo   (quo[s+1])
        );
    end

    qrm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl[QUO_W]),
        .i_quo   (quo[QUO_W]),
        .o_valid (o_valid),
        .o_degen (o_was_degenerate),
        .o_rot   (rot)
    );

    assign o_rot_r0c0 = rot[0];
    assign o_rot_r0c1 = rot[1];
    assign o_rot_r0c2 = rot[2];
    assign o_rot_r1c0 = rot[3];
    assign o_rot_r1c1 = rot[4];
    assign o_rot_r1c2 = rot[5];
    assign o_rot_r2c0 = rot[6];
    assign o_rot_r2c1 = rot[7];
    assign o_rot_r2c2 = rot[8];

`ifndef NO_ASSERTIONS
    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_degenerate |->
            o_rot_r0c0 == 16'sd16384 && o_rot_r1c1 == 16'sd16384 &&
            o_rot_r2c2 == 16'sd16384 && o_rot_r0c1 == 16'sd0 &&
            o_rot_r1c2 == 16'sd0 && o_rot_r2c0 == 16'sd0)
        else $error("degenerate result is not identity");

    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            o_rot_r0c0 <= 16'sd16384 && o_rot_r0c0 >= -16'sd16384 &&
            o_rot_r1c1 <= 16'sd16384 && o_rot_r1c1 >= -16'sd16384 &&
            o_rot_r2c2 <= 16'sd16384 && o_rot_r2c2 >= -16'sd16384)
        else $error("diagonal entry out of range");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("pipeline advance mismatch");
`endif

endmodule

// File: tb/quaternion_to_rotation_matrix_core_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core_tb
// Drives raw Q1.15 quaternions through the core with random idling on both
// sides and checks each Q2.14 rotation matrix against an exact integer model.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core_tb;
    import qrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM  = 1100;
    localparam int TAIL_FREE = 200;
    localparam int WD_LIMIT  = 2000;

    typedef struct packed {
        t_in w;
        t_in x;
        t_in y;
        t_in z;
    } t_quat;

    typedef struct {
        t_out m[9];
        logic degen;
    } t_matrix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic o_ready, o_valid, o_was_degenerate;
    t_out o_rot[9];

    t_quat   quat_queue[$];
    t_matrix matrix_queue[$];
    int      n_sent = 0, n_checked = 0, n_degen = 0, n_errors = 0;
    int      send_idle = 0, take_idle = 0, quiet_cycles = 0;
    bit      stim_done = 1'b0, tail_calm = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    quaternion_to_rotation_matrix_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x),
        .i_quat_y(i_quat_y), .i_quat_z(i_quat_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_rot_r0c0(o_rot[0]), .o_rot_r0c1(o_rot[1]), .o_rot_r0c2(o_rot[2]),
        .o_rot_r1c0(o_rot[3]), .o_rot_r1c1(o_rot[4]), .o_rot_r1c2(o_rot[5]),
        .o_rot_r2c0(o_rot[6]), .o_rot_r2c1(o_rot[7]), .o_rot_r2c2(o_rot[8]),
        .o_was_degenerate(o_was_degenerate)
    );

    // round half away from zero of 16384*num/n2, clamped
    function automatic t_out scaled_ratio(longint num, longint n2);
        longint mag, q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag * ONE_Q14 + n2) / (2 * n2);
        if (q > ONE_Q14) q = ONE_Q14;
        return t_out'((num < 0) ? -q : q);
    endfunction

    function automatic t_matrix rotation_of(t_quat q);
        t_matrix r;
        longint w, x, y, z, n2;
        longint nm[9];
        w = q.w; x = q.x; y = q.y; z = q.z;
        n2 = w*w + x*x + y*y + z*z;
        r.degen = (n2 == 0);
        nm[0] = w*w + x*x - y*y - z*z;
        nm[1] = 2 * (x*y - w*z);
        nm[2] = 2 * (x*z + w*y);
        nm[3] = 2 * (x*y + w*z);
        nm[4] = w*w - x*x + y*y - z*z;
        nm[5] = 2 * (y*z - w*x);
        nm[6] = 2 * (x*z - w*y);
        nm[7] = 2 * (y*z + w*x);
        nm[8] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < 9; i++)
            r.m[i] = r.degen ? ((i % 4 == 0) ? t_out'(ONE_Q14) : '0)
                             : scaled_ratio(nm[i], n2);
        return r;
    endfunction

    function automatic t_in rand_comp(int mode);
        case (mode)
            0: return t_in'($urandom);
            1: return t_in'($urandom_range(0, 15)) - 8;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return t_in'($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    task automatic add_quat(t_in w, t_in x, t_in y, t_in z);
        quat_queue.push_back('{w, x, y, z});
    endtask

    initial begin
        int mode;
        add_quat(0, 0, 0, 0);
        add_quat(16'sh7fff, 0, 0, 0);
        add_quat(16'sh8000, 0, 0, 0);
        add_quat(0, 16'sh7fff, 0, 0);
        add_quat(0, 0, 16'sh8000, 0);
        add_quat(0, 0, 0, 16'sh7fff);
        add_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        add_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        add_quat(1, 0, 0, 0);
        add_quat(0, 0, 0, -1);
        add_quat(1, 1, 1, 1);
        add_quat(1, -1, 1, -1);
        add_quat(23170, 23170, 0, 0);
        add_quat(23170, 0, -23170, 0);
        add_quat(-1, 16'sh7fff, 2, -3);
        add_quat(3, 1, 0, 0);
        add_quat(0, 0, 0, 0);
        for (int i = 0; i < N_RANDOM; i++) begin
            mode = $urandom_range(0, 9);
            if (mode == 9)
                add_quat(0, 0, 0, 0);
            else
                add_quat(rand_comp(mode % 4), rand_comp($urandom_range(0, 3)),
                         rand_comp(mode % 4), rand_comp($urandom_range(0, 3)));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                matrix_queue.push_back(rotation_of({i_quat_w, i_quat_x,
                                                    i_quat_y, i_quat_z}));
                n_sent <= n_sent + 1;
            end
            tail_calm <= quat_queue.size() < TAIL_FREE;
            if (!i_valid || o_ready) begin
                if (send_idle > 0) begin
                    i_valid <= 1'b0;
                    send_idle <= send_idle - 1;
                end else if (!tail_calm && $urandom_range(0, 15) == 0) begin
                    i_valid <= 1'b0;
                    send_idle <= $urandom_range(1, 18) - 1;
                end else if (quat_queue.size() > 0) begin
                    t_quat q;
                    q = quat_queue.pop_front();
                    i_valid <= 1'b1;
                    i_quat_w <= q.w; i_quat_x <= q.x;
                    i_quat_y <= q.y; i_quat_z <= q.z;
                end else begin
                    i_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
            if (take_idle > 0) begin
                i_ready <= 1'b0;
                take_idle <= take_idle - 1;
            end else if (!tail_calm && $urandom_range(0, 15) == 0) begin
                i_ready <= 1'b0;
                take_idle <= $urandom_range(1, 18) - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (matrix_queue.size() == 0) begin
                $error("unexpected matrix");
                n_errors <= n_errors + 1;
            end else begin
                t_matrix e;
                int bad;
                e = matrix_queue.pop_front();
                bad = 0;
                for (int i = 0; i < 9; i++)
                    if (o_rot[i] !== e.m[i]) begin
                        $error("rot_r%0dc%0d expected %0d actual %0d",
                               i / 3, i % 3, e.m[i], o_rot[i]);
                        bad++;
                    end
                if (o_was_degenerate !== e.degen) begin
                    $error("was_degenerate expected %0d actual %0d",
                           e.degen, o_was_degenerate);
                    bad++;
                end
                n_errors <= n_errors + bad;
                n_checked <= n_checked + 1;
                n_degen <= n_degen + e.degen;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                wait (stim_done && matrix_queue.size() == 0);
                repeat (40) @(posedge i_clk);
            end
            wait (quiet_cycles >= WD_LIMIT);
        join_any
        $display("checked %0d matrices from %0d quaternions, %0d zero inputs",
                 n_checked, n_sent, n_degen);
        if (quiet_cycles >= WD_LIMIT) begin
            $display("tb: failure");
        end else if (n_errors == 0 && matrix_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            if (matrix_queue.size() != 0)
                $error("%0d matrices never arrived", matrix_queue.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
